// ----- rtl/spi3w9_pkg.sv -----
package spi3w9_pkg;

    localparam int TX_W = 27;
    localparam int RX_W = 16;
    localparam int BIT_POS_W = 6;

    // mode codes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // transfer kinds
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [7:0] READ_CMD = 8'hFA;
    localparam logic       DC_CMD   = 1'b0;
    localparam logic       DC_DATA  = 1'b1;

    // bit counts per transfer, and first received bit of a read
    localparam logic [BIT_POS_W-1:0] BITS_SHORT = 6'd9;
    localparam logic [BIT_POS_W-1:0] BITS_WRITE = 6'd27;
    localparam logic [BIT_POS_W-1:0] BITS_READ  = 6'd34;
    localparam logic [BIT_POS_W-1:0] RX_FIRST   = 6'd18;

    typedef struct packed {
        logic        mode;
        logic [1:0]  transfer_kind;
        logic [7:0]  cmd_byte;
        logic [15:0] write_value;
        logic        miso;
    } req_item_t;

    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        mosi;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        rejected;
    } res_item_t;

endpackage

// ----- rtl/spi3w9_req_if.sv -----
interface spi3w9_req_if;
    import spi3w9_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/spi3w9_res_if.sv -----
interface spi3w9_res_if;
    import spi3w9_pkg::*;

    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/spi_three_wire_nine_bit_master.sv -----
// A request's result passes through the input register, then the result
// register, before it is offered.
// Throughput: one request per cycle unless result.ready holds the output; the bus engine updates once per request.
// rst_n (async, active low) clears the handshake and transfer state;
// the transfer comes up idle, but the result data register (cs_n included) is not reset.
module spi_three_wire_nine_bit_master (
    input  logic         clk,
    input  logic         rst_n,
    spi3w9_req_if.sink   request,
    spi3w9_res_if.source result
);
    import spi3w9_pkg::*;

    logic                 in_valid_reg;
    req_item_t            in_data_reg;
    logic                 out_valid_reg;
    res_item_t            out_data_reg;
    logic                 advance;

    logic                 active_reg, active_next;
    logic [1:0]           kind_reg, kind_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic                 phase_reg, phase_next;
    logic [TX_W-1:0]      tx_reg, tx_next;
    logic [RX_W-1:0]      rx_reg, rx_next;

    res_item_t            res_next;
    logic [TX_W-1:0]      tx_load;
    logic [BIT_POS_W-1:0] total_bits;
    logic [BIT_POS_W-1:0] rx_off;
    logic [3:0]           rx_pos;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || advance;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    // first received byte lands in the low half, each byte MSB first
    assign rx_off = bit_pos_reg - RX_FIRST;
    assign rx_pos = {rx_off[3], ~rx_off[2:0]};

    always_comb
    begin
        case (in_data_reg.transfer_kind)
            KIND_CMD:
                tx_load = {DC_CMD, in_data_reg.cmd_byte, 18'b0};
            KIND_DATA:
                tx_load = {DC_DATA, in_data_reg.write_value[7:0], 18'b0};
            KIND_WRITE:
                tx_load = {DC_CMD, in_data_reg.cmd_byte,
                           DC_DATA, in_data_reg.write_value[7:0],
                           DC_DATA, in_data_reg.write_value[15:8]};
            KIND_READ:
                tx_load = {DC_CMD, in_data_reg.cmd_byte, DC_CMD, READ_CMD, 9'b0};
            default:
                tx_load = '0;
        endcase
    end

    always_comb
    begin
        case (kind_reg)
            KIND_WRITE: total_bits = BITS_WRITE;
            KIND_READ:  total_bits = BITS_READ;
            default:    total_bits = BITS_SHORT;
        endcase
    end

    always_comb
    begin
        active_next  = active_reg;
        kind_next    = kind_reg;
        bit_pos_next = bit_pos_reg;
        phase_next   = phase_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        res_next     = '0;
        res_next.cs_n = 1'b1;

        if (in_data_reg.mode == MODE_START)
        begin
            if (active_reg)
            begin
                res_next.rejected = 1'b1;
            end
            else
            begin
                active_next  = 1'b1;
                kind_next    = in_data_reg.transfer_kind;
                bit_pos_next = '0;
                phase_next   = 1'b0;
                tx_next      = tx_load;
                rx_next      = '0;
            end
            res_next.cs_n = !active_next;
        end
        else if (active_reg)
        begin
            res_next.cs_n = 1'b0;
            res_next.mosi = tx_reg[TX_W-1];
            if (!phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                res_next.sclk = 1'b1;
                if (kind_reg == KIND_READ && bit_pos_reg >= RX_FIRST
                    && bit_pos_reg < BITS_READ)
                begin
                    rx_next[rx_pos] = rx_reg[rx_pos] | in_data_reg.miso;
                end
                tx_next      = {tx_reg[TX_W-2:0], 1'b0};
                bit_pos_next = bit_pos_reg + 1'b1;
                phase_next   = 1'b0;
                if (bit_pos_next >= total_bits)
                begin
                    active_next       = 1'b0;
                    res_next.done_res = 1'b1;
                    if (kind_reg == KIND_READ)
                    begin
                        res_next.read_value = rx_next;
                    end
                end
            end
        end
        res_next.busy_res = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            kind_reg      <= '0;
            bit_pos_reg   <= '0;
            phase_reg     <= 1'b0;
            tx_reg        <= '0;
            rx_reg        <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                in_valid_reg <= request.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= active_next;
                kind_reg      <= kind_next;
                bit_pos_reg   <= bit_pos_next;
                phase_reg     <= phase_next;
                tx_reg        <= tx_next;
                rx_reg        <= rx_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_data_reg <= request.data;
        end
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end

    a_phase_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> active_reg)
        else $error("clock high half pending with no transfer active");

    a_done_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.done_res |=> !active_reg && out_valid_reg)
        else $error("done reported but transfer still active");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.rejected |-> active_reg && active_next)
        else $error("start rejected while idle");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.done_res |->
            result.data.sclk && !result.data.cs_n && !result.data.busy_res
            && !result.data.rejected)
        else $error("malformed ending tick");

endmodule
